[hdl/ffca_pkg.sv]
// Package for the first-fit chunk allocator: types, codes and widths.
`default_nettype none
package ffca_pkg;

   localparam int ADDR_W = 16;
   localparam int SIZE_W = 17;
   localparam logic [SIZE_W-1:0] SIZE_CAP = 17'h1FFFF;

   // request command codes
   typedef enum logic [1:0] {
      CMD_ALLOC    = 2'd0,
      CMD_FREE     = 2'd1,
      CMD_COALESCE = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

   // response status codes
   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_ZERO    = 3'd1,
      ST_NOFIT   = 3'd2,
      ST_UNKNOWN = 3'd3,
      ST_FULL    = 3'd4
   } st_type;

   // one table entry: chunk start and size
   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [SIZE_W-1:0] size;
   } entry_type;

   // datapath operations
   typedef enum logic [3:0] {
      OP_IDLE,
      OP_INIT,
      OP_DECODE,
      OP_SCAN_FREE,
      OP_REM_FREE,
      OP_INS_USED,
      OP_INS_TAIL,
      OP_SCAN_USED,
      OP_INS_FREE,
      OP_REM_USED,
      OP_MERGE,
      OP_REPLY
   } op_type;

   // controller states
   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_DECODE,
      S_SCAN_FREE,
      S_REM_FREE,
      S_INS_USED,
      S_INS_TAIL,
      S_SCAN_USED,
      S_INS_FREE,
      S_REM_USED,
      S_MERGE,
      S_REPLY
   } state_type;

   // controller to datapath
   typedef struct packed {
      op_type op;
      logic   start;
      logic   load;
      logic   set_status;
      st_type status;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic    done;
      logic    found;
      logic    used_full;
      logic    free_full;
      logic    size_zero;
      logic    tail_nz;
      cmd_type cmd;
   } sts_type;

endpackage
`default_nettype wire

[hdl/ffca_datapath.sv]
// Datapath: chunk tables, counts, scan/shift/merge sequencing and result register.
`default_nettype none
module ffca_datapath #(
   parameter int TABLE_SLOTS = 1024,
   parameter longint unsigned HEAP_BYTES = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ffca_pkg::ctl_type        ctl,
   output ffca_pkg::sts_type             sts,
   input  wire logic [1:0]               req_cmd,
   input  wire logic [16:0]              req_size,
   input  wire logic [15:0]              req_addr,
   input  wire logic                     rsp_ready,
   output logic                          rsp_valid,
   output logic [15:0]                   rsp_grant_addr,
   output logic [2:0]                    rsp_status
);
   import ffca_pkg::*;

   localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CW = $clog2(TABLE_SLOTS + 1);
   localparam logic [SIZE_W-1:0] FIRST_SIZE =
      (HEAP_BYTES > 64'd131071) ? SIZE_CAP : SIZE_W'(HEAP_BYTES);

   // tables
   entry_type free_mem [TABLE_SLOTS];
   entry_type used_mem [TABLE_SLOTS];
   entry_type free_q_ff, used_q_ff;

   // request and result registers
   cmd_type           cmd_ff, cmd_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   st_type            status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] grant_ff, grant_in;
   st_type            rsp_status_ff, rsp_status_in;

   // sequencing registers
   logic [CW-1:0] free_cnt_ff, free_cnt_in;
   logic [CW-1:0] used_cnt_ff, used_cnt_in;
   logic [CW-1:0] rp_ff, rp_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [CW-1:0] hit_idx_ff, hit_idx_in;
   entry_type     hit_ff, hit_in;
   logic          found_ff, found_in;
   logic [CW-1:0] w_ff, w_in;
   entry_type     acc_ff, acc_in;
   logic          acc_vld_ff, acc_vld_in;
   logic          fin_ff, fin_in;

   // combinational
   logic          tbl_free;
   logic [CW-1:0] tbl_cnt, cnt_next, last_idx;
   entry_type     tbl_q, ins_val, wr_data;
   logic          tbl_we, done;
   logic [CW-1:0] iss_addr, wr_addr;
   logic          match, joined;
   logic [17:0]   end_sum, size_sum;

   assign tbl_free = (ctl.op inside {OP_SCAN_FREE, OP_REM_FREE, OP_INS_TAIL,
                                     OP_INS_FREE, OP_MERGE, OP_INIT});
   assign tbl_cnt  = tbl_free ? free_cnt_ff : used_cnt_ff;
   assign tbl_q    = tbl_free ? free_q_ff : used_q_ff;
   assign last_idx = CW'(tbl_cnt - 1'b1);
   assign end_sum  = {2'b00, acc_ff.start} + {1'b0, acc_ff.size};
   assign joined   = acc_vld_ff && (end_sum == {2'b00, tbl_q.start});
   assign size_sum = {1'b0, acc_ff.size} + {1'b0, tbl_q.size};
   assign match    = (ctl.op == OP_SCAN_FREE) ? (tbl_q.size >= size_ff)
                                              : (tbl_q.start == addr_ff);

   // value to insert
   always_comb begin
      case (ctl.op)
         OP_INS_USED: ins_val = '{start: hit_ff.start, size: size_ff};
         OP_INS_TAIL: ins_val = '{start: ADDR_W'(hit_ff.start + size_ff[ADDR_W-1:0]),
                                  size: SIZE_W'(hit_ff.size - size_ff)};
         default:     ins_val = hit_ff;
      endcase
   end

   // operation sequencing
   always_comb begin
      cmd_in        = cmd_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      grant_in      = grant_ff;
      rsp_status_in = rsp_status_ff;
      rp_in         = rp_ff;
      rd_vld_in     = 1'b0;
      iss_addr      = '0;
      hit_idx_in    = hit_idx_ff;
      hit_in        = hit_ff;
      found_in      = found_ff;
      w_in          = w_ff;
      acc_in        = acc_ff;
      acc_vld_in    = acc_vld_ff;
      fin_in        = fin_ff;
      cnt_next      = tbl_cnt;
      tbl_we        = 1'b0;
      wr_addr       = '0;
      wr_data       = ins_val;
      done          = 1'b0;

      if (ctl.load) begin
         cmd_in    = cmd_type'(req_cmd);
         size_in   = req_size;
         addr_in   = req_addr;
         status_in = ST_OK;
      end
      if (ctl.set_status) begin
         status_in = ctl.status;
      end

      case (ctl.op)
         OP_INIT: begin
            tbl_we  = 1'b1;
            wr_data = '{start: '0, size: FIRST_SIZE};
            done    = 1'b1;
         end
         OP_SCAN_FREE, OP_SCAN_USED: begin
            if (ctl.start) begin
               found_in = 1'b0;
               if (tbl_cnt == '0) begin
                  done = 1'b1;
               end else begin
                  rd_vld_in = 1'b1;
                  rp_in     = CW'(1);
               end
            end else if (rd_vld_ff) begin
               if (match) begin
                  found_in   = 1'b1;
                  hit_in     = tbl_q;
                  hit_idx_in = rd_idx_ff;
                  done       = 1'b1;
               end else if (rd_idx_ff == last_idx) begin
                  done = 1'b1;
               end else begin
                  rd_vld_in = 1'b1;
                  iss_addr  = rp_ff;
                  rp_in     = CW'(rp_ff + 1'b1);
               end
            end
         end
         OP_REM_FREE, OP_REM_USED: begin
            // shift the entries above the hit down by one
            if (ctl.start) begin
               if (CW'(hit_idx_ff + 1'b1) >= tbl_cnt) begin
                  cnt_next = last_idx;
                  done     = 1'b1;
               end else begin
                  rd_vld_in = 1'b1;
                  iss_addr  = CW'(hit_idx_ff + 1'b1);
                  rp_in     = CW'(hit_idx_ff + 2'd2);
               end
            end else if (rd_vld_ff) begin
               tbl_we  = 1'b1;
               wr_addr = CW'(rd_idx_ff - 1'b1);
               wr_data = tbl_q;
               if (rd_idx_ff == last_idx) begin
                  cnt_next = last_idx;
                  done     = 1'b1;
               end else begin
                  rd_vld_in = 1'b1;
                  iss_addr  = rp_ff;
                  rp_in     = CW'(rp_ff + 1'b1);
               end
            end
         end
         OP_INS_USED, OP_INS_TAIL, OP_INS_FREE: begin
            // walk down from the top, shifting larger starts up by one
            if (ctl.start) begin
               fin_in = 1'b0;
               if (tbl_cnt == '0) begin
                  tbl_we   = 1'b1;
                  cnt_next = CW'(tbl_cnt + 1'b1);
                  done     = 1'b1;
               end else begin
                  rd_vld_in = 1'b1;
                  iss_addr  = last_idx;
                  rp_in     = CW'(last_idx - 1'b1);
               end
            end else if (fin_ff) begin
               tbl_we   = 1'b1;
               cnt_next = CW'(tbl_cnt + 1'b1);
               fin_in   = 1'b0;
               done     = 1'b1;
            end else if (rd_vld_ff) begin
               tbl_we  = 1'b1;
               wr_addr = CW'(rd_idx_ff + 1'b1);
               if (tbl_q.start > ins_val.start) begin
                  wr_data = tbl_q;
                  if (rd_idx_ff == '0) begin
                     fin_in = 1'b1;
                  end else begin
                     rd_vld_in = 1'b1;
                     iss_addr  = rp_ff;
                     rp_in     = CW'(rp_ff - 1'b1);
                  end
               end else begin
                  cnt_next = CW'(tbl_cnt + 1'b1);
                  done     = 1'b1;
               end
            end
         end
         OP_MERGE: begin
            // accumulator holds the chunk being grown, written when it ends
            if (ctl.start) begin
               acc_vld_in = 1'b0;
               w_in       = '0;
               fin_in     = 1'b0;
               if (tbl_cnt == '0) begin
                  done = 1'b1;
               end else begin
                  rd_vld_in = 1'b1;
                  rp_in     = CW'(1);
               end
            end else if (fin_ff) begin
               tbl_we   = 1'b1;
               wr_addr  = w_ff;
               wr_data  = acc_ff;
               cnt_next = CW'(w_ff + 1'b1);
               fin_in   = 1'b0;
               done     = 1'b1;
            end else if (rd_vld_ff) begin
               if (joined) begin
                  acc_in.size = size_sum[17] ? SIZE_CAP : size_sum[SIZE_W-1:0];
               end else begin
                  if (acc_vld_ff) begin
                     tbl_we  = 1'b1;
                     wr_addr = w_ff;
                     wr_data = acc_ff;
                     w_in    = CW'(w_ff + 1'b1);
                  end
                  acc_in     = tbl_q;
                  acc_vld_in = 1'b1;
               end
               if (rd_idx_ff == last_idx) begin
                  fin_in = 1'b1;
               end else begin
                  rd_vld_in = 1'b1;
                  iss_addr  = rp_ff;
                  rp_in     = CW'(rp_ff + 1'b1);
               end
            end
         end
         OP_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               grant_in      = (cmd_ff == CMD_ALLOC && status_ff == ST_OK)
                               ? hit_ff.start : '0;
               done          = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (tbl_free) begin
         free_cnt_in = cnt_next;
         used_cnt_in = used_cnt_ff;
      end else begin
         free_cnt_in = free_cnt_ff;
         used_cnt_in = cnt_next;
      end
   end

   assign rd_idx_in = iss_addr;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         free_cnt_ff  <= CW'(1);
         used_cnt_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fin_ff       <= 1'b0;
         acc_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         free_cnt_ff  <= free_cnt_in;
         used_cnt_ff  <= used_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         fin_ff       <= fin_in;
         acc_vld_ff   <= acc_vld_in;
         found_ff     <= found_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      status_ff     <= status_in;
      grant_ff      <= grant_in;
      rsp_status_ff <= rsp_status_in;
      rp_ff         <= rp_in;
      rd_idx_ff     <= rd_idx_in;
      hit_idx_ff    <= hit_idx_in;
      hit_ff        <= hit_in;
      w_ff          <= w_in;
      acc_ff        <= acc_in;
   end

   // free table memory
   always_ff @(posedge clock) begin
      if (tbl_we && tbl_free) begin
         free_mem[wr_addr[IW-1:0]] <= wr_data;
      end
      free_q_ff <= free_mem[iss_addr[IW-1:0]];
   end

   // used table memory
   always_ff @(posedge clock) begin
      if (tbl_we && !tbl_free) begin
         used_mem[wr_addr[IW-1:0]] <= wr_data;
      end
      used_q_ff <= used_mem[iss_addr[IW-1:0]];
   end

   // status to the controller
   always_comb begin
      sts.done      = done;
      sts.found     = found_in;
      sts.used_full = (used_cnt_ff >= CW'(TABLE_SLOTS));
      sts.free_full = (free_cnt_ff >= CW'(TABLE_SLOTS));
      sts.size_zero = (size_ff == '0);
      sts.tail_nz   = (hit_ff.size != size_ff);
      sts.cmd       = cmd_ff;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_grant_addr = grant_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
`default_nettype wire

[hdl/ffca_controller.sv]
// Controller: state machine that steps the datapath through each command.
`default_nettype none
module ffca_controller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ffca_pkg::sts_type sts,
   output ffca_pkg::ctl_type      ctl
);
   import ffca_pkg::*;

   state_type state_ff, state_in;
   logic      start_ff, start_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT:      if (sts.done) state_in = S_IDLE;
         S_IDLE:      if (req_valid) state_in = S_DECODE;
         S_DECODE: begin
            case (sts.cmd)
               CMD_ALLOC:    state_in = sts.size_zero ? S_REPLY : S_SCAN_FREE;
               CMD_FREE:     state_in = S_SCAN_USED;
               CMD_COALESCE: state_in = S_MERGE;
               default:      state_in = S_REPLY;
            endcase
         end
         S_SCAN_FREE: begin
            if (sts.done) begin
               state_in = (!sts.found || sts.used_full) ? S_REPLY : S_REM_FREE;
            end
         end
         S_REM_FREE:  if (sts.done) state_in = S_INS_USED;
         S_INS_USED:  if (sts.done) state_in = sts.tail_nz ? S_INS_TAIL : S_REPLY;
         S_INS_TAIL:  if (sts.done) state_in = S_REPLY;
         S_SCAN_USED: begin
            if (sts.done) begin
               state_in = (!sts.found || sts.free_full) ? S_REPLY : S_INS_FREE;
            end
         end
         S_INS_FREE:  if (sts.done) state_in = S_REM_USED;
         S_REM_USED:  if (sts.done) state_in = S_REPLY;
         S_MERGE:     if (sts.done) state_in = S_REPLY;
         S_REPLY:     if (sts.done) state_in = S_IDLE;
         default:     state_in = S_INIT;
      endcase
   end

   assign start_in = (state_in != state_ff);

   // outputs
   always_comb begin
      ctl.op         = OP_IDLE;
      ctl.start      = start_ff;
      ctl.load       = 1'b0;
      ctl.set_status = 1'b0;
      ctl.status     = ST_OK;
      req_ready      = 1'b0;
      case (state_ff)
         S_INIT: ctl.op = OP_INIT;
         S_IDLE: begin
            req_ready = 1'b1;
            ctl.load  = req_valid;
         end
         S_DECODE: begin
            ctl.op = OP_DECODE;
            if (sts.cmd == CMD_ALLOC && sts.size_zero) begin
               ctl.set_status = 1'b1;
               ctl.status     = ST_ZERO;
            end
         end
         S_SCAN_FREE: begin
            ctl.op = OP_SCAN_FREE;
            if (sts.done && !sts.found) begin
               ctl.set_status = 1'b1;
               ctl.status     = ST_NOFIT;
            end else if (sts.done && sts.used_full) begin
               ctl.set_status = 1'b1;
               ctl.status     = ST_FULL;
            end
         end
         S_REM_FREE: ctl.op = OP_REM_FREE;
         S_INS_USED: ctl.op = OP_INS_USED;
         S_INS_TAIL: ctl.op = OP_INS_TAIL;
         S_SCAN_USED: begin
            ctl.op = OP_SCAN_USED;
            if (sts.done && !sts.found) begin
               ctl.set_status = 1'b1;
               ctl.status     = ST_UNKNOWN;
            end else if (sts.done && sts.free_full) begin
               ctl.set_status = 1'b1;
               ctl.status     = ST_FULL;
            end
         end
         S_INS_FREE: ctl.op = OP_INS_FREE;
         S_REM_USED: ctl.op = OP_REM_USED;
         S_MERGE:    ctl.op = OP_MERGE;
         S_REPLY:    ctl.op = OP_REPLY;
         default:    ctl.op = OP_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         start_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
      end
   end

endmodule
`default_nettype wire

[hdl/first_fit_chunk_allocator.sv]
// First-fit chunk allocator over a byte heap: top level.
//
// Requests (req_cmd, req_size, req_addr) arrive on a valid/ready channel and
// each produces exactly one response (rsp_grant_addr, rsp_status) on a second
// valid/ready channel. Commands: allocate, free, coalesce free neighbours.
// One request is worked on at a time; req_ready is high only while idle.
// Steps per request, over F free and U used entries:
//   allocate: scan F, shift the hit out of F, insert into U, then insert
//             any nonzero tail back into F
//   free:     scan U, insert into F, then shift the entry out of U
//   coalesce: one merge pass over F; a failed scan ends the request.
// Each table has one read and one write port, so every step walks its table
// one entry at a time and the work grows with the entry counts.
// After reset the block first writes the initial whole-heap
// entry, then raises req_ready. The finished response waits in an output
// register; a stalled receiver holds the block in its reply step, but the
// next request is accepted as soon as that response has been loaded.
`default_nettype none
module first_fit_chunk_allocator #(
   parameter int TABLE_SLOTS = 1024,
   parameter longint unsigned HEAP_BYTES = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [16:0] req_size,
   input  wire logic [15:0] req_addr,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_grant_addr,
   output logic [2:0]       rsp_status
);
   import ffca_pkg::*;

   ctl_type ctl;
   sts_type sts;

   ffca_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   ffca_datapath #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .HEAP_BYTES  (HEAP_BYTES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .sts            (sts),
      .req_cmd        (req_cmd),
      .req_size       (req_size),
      .req_addr       (req_addr),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_grant_addr (rsp_grant_addr),
      .rsp_status     (rsp_status)
   );

endmodule
`default_nettype wire

[hdl/ffca_checker.sv]
// Port-level checks for the chunk allocator and their bind to the top level.
`default_nettype none
module ffca_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_grant_addr,
   input wire logic [2:0]  rsp_status
);
   import ffca_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_grant_addr)
                                  && $stable(rsp_status))
      else $error("response changed while stalled");

   // only a successful transfer carries an address
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_grant_addr == '0)
      else $error("grant address on a failed request");

   // one request at a time: busy right after a request transfer
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // no response straight out of reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind first_fit_chunk_allocator ffca_checker u_ffca_checker (.*);
`default_nettype wire
